// ----- hw/rtl/first_fit_block_allocator_defines.svh -----
// Assertion macros for the first-fit block allocator.
// Included by RTL files that carry concurrent checks; depends on nothing else.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffba assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffba assertion failed");

`else

`define FFBA_ASSERT_IMPL(name, clk, rst, ante, cons)
`define FFBA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/ffba_pkg.sv -----
// Shared constants, codes and helper functions for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int POOL_BYTES = 32;
  localparam int ADDR_W     = $clog2(POOL_BYTES);
  // Wide enough for a header offset plus a full length byte plus the header.
  localparam int CELL_W     = $clog2(POOL_BYTES + 258);
  localparam int BYTE_W     = 8;

  localparam int OP_W     = 1;
  localparam int SIZE_W   = 5;
  localparam int HANDLE_W = 5;
  localparam int STATUS_W = 2;
  localparam int OUTA_W   = 5;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;

  localparam logic [BYTE_W-1:0] HDR_USED = 8'd0;
  localparam logic [BYTE_W-1:0] HDR_FREE = 8'd1;

  // Contents of a pool byte that has not been written since reset.
  function automatic logic [BYTE_W-1:0] pool_reset_byte(input logic [ADDR_W-1:0] a);
    logic [BYTE_W-1:0] v;
    v = '0;
    if (a == ADDR_W'(0)) begin
      v = HDR_FREE;
    end else if (a == ADDR_W'(1)) begin
      v = BYTE_W'(POOL_BYTES - 3);
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/first_fit_block_allocator.sv -----
// First-fit block allocator top level: sequencer, pool memory and result register.
// Depends on ffba_pkg and first_fit_block_allocator_defines.svh.
//
// Usage:
//   The request channel (req_valid/req_stall) carries operation, request_size
//   and handle. The response channel (rsp_valid/rsp_stall) carries status and
//   address, one response beat per request beat, in order.
//   A free request writes one flag byte if its handle is in range; its response
//   is then loaded from the done state. An allocate walks the headers from
//   offset 0, each with two reads of the pool read port and a decision. A fit
//   adds the header writes and the load of the response. The next request can
//   be accepted in the cycle after the response is loaded.
//   One request is in work at a time: req_stall is high from acceptance until
//   the result has been loaded into the response register.
//   A result waiting in the response register does not block the next
//   request; a finished item waits only if the register is still held by a
//   stalled beat. Reset clears the valid bits of the pool, which then reads as
//   one free block spanning the whole pool, and drops any pending response.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [ffba_pkg::OP_W-1:0]       operation,
  input  logic [ffba_pkg::SIZE_W-1:0]     request_size,
  input  logic [ffba_pkg::HANDLE_W-1:0]   handle,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [ffba_pkg::STATUS_W-1:0]   status,
  output logic [ffba_pkg::OUTA_W-1:0]     address
);
  import ffba_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_FLAG = 3'd1;
  localparam logic [2:0] S_RD_LEN  = 3'd2;
  localparam logic [2:0] S_CHECK   = 3'd3;
  localparam logic [2:0] S_W_LEN   = 3'd4;
  localparam logic [2:0] S_W_RFLAG = 3'd5;
  localparam logic [2:0] S_W_RLEN  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]          state;
  logic [CELL_W-1:0]   hdr_pos;
  logic [SIZE_W-1:0]   size_q;
  logic                flag_free;
  logic                bound_ok;
  logic [BYTE_W-1:0]   rest;
  logic [STATUS_W-1:0] res_status;
  logic [OUTA_W-1:0]   res_addr;

  // Pool memory with one write and one registered read port.
  logic [BYTE_W-1:0]     mem [POOL_BYTES];
  logic [POOL_BYTES-1:0] written;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [BYTE_W-1:0]     rdata;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [BYTE_W-1:0]     wr_data;

  // Shared adder: offset arithmetic relative to the current header.
  logic [CELL_W-1:0] unit_b;
  logic [CELL_W-1:0] unit_sum;

  logic              req_fire;
  logic              rsp_load;
  logic [CELL_W-1:0] handle_ext;
  logic              free_ok;
  logic [BYTE_W-1:0] need;
  logic              fit;
  logic [ADDR_W-1:0] hdr_pos_lo;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  assign hdr_pos_lo = hdr_pos[ADDR_W-1:0];
  assign handle_ext = CELL_W'(handle);
  assign free_ok    = (handle_ext >= CELL_W'(2)) &&
                      ((handle_ext - CELL_W'(2)) < CELL_W'(POOL_BYTES));
  assign need       = BYTE_W'(size_q) + BYTE_W'(2);
  assign fit        = flag_free && bound_ok && (rdata > need);

  always_comb begin
    case (state)
      S_CHECK:   unit_b = CELL_W'(rdata) + CELL_W'(2);
      S_W_RFLAG: unit_b = CELL_W'(size_q);
      default:   unit_b = CELL_W'(size_q) + CELL_W'(1);
    endcase
  end
  assign unit_sum = hdr_pos + unit_b;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = hdr_pos_lo - ADDR_W'(2);
    wr_en   = 1'b0;
    wr_addr = hdr_pos_lo - ADDR_W'(2);
    wr_data = HDR_USED;
    unique case (state)
      S_IDLE: begin
        if (req_fire && operation == OP_FREE && free_ok) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(handle_ext - CELL_W'(2));
          wr_data = HDR_FREE;
        end
      end
      S_RD_FLAG: begin
        rd_en = (hdr_pos < CELL_W'(POOL_BYTES - 1));
      end
      S_RD_LEN: begin
        rd_en   = 1'b1;
        rd_addr = hdr_pos_lo - ADDR_W'(1);
      end
      S_CHECK: begin
        wr_en = fit;
      end
      S_W_LEN: begin
        wr_en   = 1'b1;
        wr_addr = hdr_pos_lo - ADDR_W'(1);
        wr_data = BYTE_W'(size_q);
      end
      S_W_RFLAG: begin
        wr_en   = 1'b1;
        wr_addr = unit_sum[ADDR_W-1:0];
        wr_data = HDR_FREE;
      end
      S_W_RLEN: begin
        wr_en   = 1'b1;
        wr_addr = unit_sum[ADDR_W-1:0];
        wr_data = rest;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Bytes never written since reset read as the reset image of the pool.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= written[rd_addr] ? mem[rd_addr] : pool_reset_byte(rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= (operation == OP_FREE) ? S_DONE : S_RD_FLAG;
          end
        end
        S_RD_FLAG: begin
          state <= (hdr_pos < CELL_W'(POOL_BYTES - 1)) ? S_RD_LEN : S_DONE;
        end
        S_RD_LEN:  state <= S_CHECK;
        S_CHECK:   state <= fit ? S_W_LEN : S_RD_FLAG;
        S_W_LEN:   state <= S_W_RFLAG;
        S_W_RFLAG: state <= S_W_RLEN;
        S_W_RLEN:  state <= S_DONE;
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        hdr_pos    <= CELL_W'(2);
        size_q     <= request_size;
        res_status <= ST_FREED;
        res_addr   <= '0;
      end
      S_RD_FLAG: begin
        bound_ok   <= (unit_sum < CELL_W'(POOL_BYTES));
        res_status <= ST_NO_FIT;
        res_addr   <= '0;
      end
      S_RD_LEN: begin
        flag_free <= (rdata == HDR_FREE);
      end
      S_CHECK: begin
        rest <= rdata - need;
        if (!fit) begin
          hdr_pos <= unit_sum;
        end
      end
      S_W_RLEN: begin
        res_status <= ST_ALLOCATED;
        res_addr   <= hdr_pos[OUTA_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status  <= res_status;
      address <= res_addr;
    end
  end

  `FFBA_ASSERT_NEXT(a_free_one_step, clk, rst, req_fire && operation == OP_FREE, state == S_DONE)
  `FFBA_ASSERT_IMPL(a_addr_zero_unless_alloc, clk, rst, rsp_valid && status != ST_ALLOCATED, address == '0)
  `FFBA_ASSERT_IMPL(a_rsp_from_done, clk, rst, $rose(rsp_valid), $past(state) == S_DONE)
  `FFBA_ASSERT_IMPL(a_single_port_use, clk, rst, wr_en, !rd_en)

endmodule
